// ----- design/euc_iso_case_converter_defines.svh -----
// assertion macros shared by the case converter rtl
// expects signals named clk and rst in the module that uses them
`ifndef EUC_ISO_CASE_CONVERTER_DEFINES_SVH
`define EUC_ISO_CASE_CONVERTER_DEFINES_SVH

`ifndef SYNTH
// property holds at every clock edge out of reset
`define EIC_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");
// antecedent implies consequent in the following cycle
`define EIC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define EIC_ASSERT_ALWAYS(lbl, expr)
`define EIC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- design/eic_pkg.sv -----
// package for the case converter: constants, config type, case map function
// no dependencies
package eic_pkg;

  localparam int CNT_W     = 16;
  localparam int BYTE_W    = 8;
  localparam int REM_W     = 2;
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;

  localparam logic [BYTE_W-1:0] SS3_LEAD = 8'd143;
  localparam logic [BYTE_W-1:0] KOR_LO   = 8'hA1;
  localparam logic [BYTE_W-1:0] KOR_HI   = 8'hFE;
  localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};

  // register indexes (paddr[3:2])
  typedef enum logic [1:0] {
    REG_CODE_SET  = 2'd0,
    REG_TO_UPPER  = 2'd1,
    REG_SINGLE_BC = 2'd2,
    REG_NONE      = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic code_set;
    logic to_upper;
    logic single_byte_compare;
  } cfg_t;

  // ascii case map, plus latin-1 map when latin is set
  function automatic logic [BYTE_W-1:0] map_case(input logic [BYTE_W-1:0] b,
                                                 input logic up,
                                                 input logic latin);
    logic [BYTE_W-1:0] r;
    r = b;
    if (up) begin
      if (b >= 8'h61 && b <= 8'h7A) r = b - 8'h20;
      else if (latin && b >= 8'hE0 && b <= 8'hFE && b != 8'hF7) r = b - 8'h20;
    end else begin
      if (b >= 8'h41 && b <= 8'h5A) r = b + 8'h20;
      else if (latin && b >= 8'hC0 && b <= 8'hDE && b != 8'hD7) r = b + 8'h20;
    end
    return r;
  endfunction

endpackage

// ----- design/eic_in_if.sv -----
// input channel: one raw byte per transaction
// depends on eic_pkg
interface eic_in_if;
  import eic_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              last_byte;

  modport source (output valid, output in_byte, output last_byte, input ready);
  modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

// ----- design/eic_out_if.sv -----
// output channel: one converted byte and running count per transaction
// depends on eic_pkg
interface eic_out_if;
  import eic_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic [CNT_W-1:0]  char_total;
  logic              end_of_string;

  modport source (output valid, output out_byte, output char_total,
                  output end_of_string, input ready);
  modport sink   (input valid, input out_byte, input char_total,
                  input end_of_string, output ready);
endinterface

// ----- design/eic_core.sv -----
// per-byte framing, case mapping and character counting
// depends on eic_pkg and the assertion macro header
`include "euc_iso_case_converter_defines.svh"

module eic_core (
  input  logic                     clk,
  input  logic                     rst,
  input  eic_pkg::cfg_t            cfg,
  input  logic                     advance,
  input  logic [eic_pkg::BYTE_W-1:0] in_byte,
  input  logic                     last_byte,
  output logic [eic_pkg::BYTE_W-1:0] out_byte,
  output logic [eic_pkg::CNT_W-1:0]  char_total
);
  import eic_pkg::*;

  logic [REM_W-1:0] rem, rem_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             step;

  // framing and mapping of the current byte
  always_comb begin
    out_byte = in_byte;
    rem_next = rem;
    step     = 1'b0;
    if (rem != '0) begin
      rem_next = rem - 1'b1;
      step     = cfg.code_set && (rem == REM_W'(1));
    end else if (cfg.code_set) begin
      if (!in_byte[BYTE_W-1]) begin
        out_byte = map_case(in_byte, cfg.to_upper, 1'b0);
        step     = 1'b1;
      end else if (in_byte == SS3_LEAD) begin
        rem_next = REM_W'(2);
      end else begin
        rem_next = REM_W'(1);
      end
    end else begin
      if (!cfg.single_byte_compare && in_byte >= KOR_LO && in_byte <= KOR_HI) begin
        rem_next = REM_W'(2);
      end else begin
        out_byte = map_case(in_byte, cfg.to_upper, 1'b1);
      end
      step = 1'b1;
    end
    cnt_next   = (step && cnt != CNT_MAX) ? cnt + 1'b1 : cnt;
    char_total = cnt_next;
  end

  // state, cleared after the last byte of a string
  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= '0;
      cnt <= '0;
    end else if (advance) begin
      rem <= last_byte ? '0 : rem_next;
      cnt <= last_byte ? '0 : cnt_next;
    end
  end

  `EIC_ASSERT_ALWAYS(a_rem_range, rem != 2'd3)
  `EIC_ASSERT_NEXT(a_clear_on_last, advance && last_byte, rem == '0 && cnt == '0)
  `EIC_ASSERT_NEXT(a_cnt_monotonic, advance && !last_byte, cnt >= $past(cnt))

endmodule

// ----- design/euc_iso_case_converter.sv -----
// Data path: an accepted byte passes through the input reg, then the result reg.
// Throughput: one byte per cycle while the output is ready; the combinational map between
// the two registers is the only work per byte, and the result register sets the pace.
// Reset: synchronous, active high; clears config registers, framing state,
// character counter and both valid flags.
// depends on eic_pkg, eic_in_if, eic_out_if, eic_core
`include "euc_iso_case_converter_defines.svh"

module euc_iso_case_converter (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [eic_pkg::PADDR_W-1:0] paddr,
  input  logic [eic_pkg::PDATA_W-1:0] pwdata,
  output logic [eic_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  eic_in_if.sink                      feed,
  eic_out_if.source                   result
);
  import eic_pkg::*;

  cfg_t              cfg;
  reg_idx_t          reg_idx;
  logic              wr_en;

  logic              s1_valid;
  logic [BYTE_W-1:0] s1_byte;
  logic              s1_last;
  logic              advance;

  logic [BYTE_W-1:0] map_byte;
  logic [CNT_W-1:0]  map_total;

  // configuration port
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_CODE_SET:  cfg.code_set            <= pwdata[0];
        REG_TO_UPPER:  cfg.to_upper            <= pwdata[0];
        REG_SINGLE_BC: cfg.single_byte_compare <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_CODE_SET:  prdata[0] = cfg.code_set;
      REG_TO_UPPER:  prdata[0] = cfg.to_upper;
      REG_SINGLE_BC: prdata[0] = cfg.single_byte_compare;
      default: ;
    endcase
  end

  // handshake: input stage moves on whenever the result register is free
  assign advance    = s1_valid && (!result.valid || result.ready);
  assign feed.ready = !s1_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (feed.ready) begin
      s1_valid <= feed.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (feed.valid && feed.ready) begin
      s1_byte <= feed.in_byte;
      s1_last <= feed.last_byte;
    end
  end

  eic_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .advance    (advance),
    .in_byte    (s1_byte),
    .last_byte  (s1_last),
    .out_byte   (map_byte),
    .char_total (map_total)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (advance) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.out_byte      <= map_byte;
      result.char_total    <= map_total;
      result.end_of_string <= s1_last;
    end
  end

  `EIC_ASSERT_NEXT(a_accept_loads, feed.valid && feed.ready, s1_valid)
  `EIC_ASSERT_NEXT(a_stage_holds, s1_valid && !advance, s1_valid && $stable(s1_byte) && $stable(s1_last))
  `EIC_ASSERT_NEXT(a_advance_shows, advance, result.valid)

endmodule

// ----- verif/euc_iso_case_converter_tb.sv -----
`timescale 1ns / 100ps
// testbench for euc_iso_case_converter: apb register setup, byte strings with
// random gaps and a long output hold-off, each result checked against a case-map predictor
// depends on eic_pkg, eic_in_if, eic_out_if and the converter rtl

module euc_iso_case_converter_tb;
  import eic_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int LONG_HOLD   = 300;
  localparam int RAND_PHASES = 12;
  localparam int PHASE_BYTES = 70;

  typedef struct packed {
    logic [BYTE_W-1:0] in_byte;
    logic              last_byte;
  } raw_byte_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic [CNT_W-1:0]  char_total;
    logic              end_of_string;
  } conv_result_t;

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  eic_in_if  feed_if ();
  eic_out_if result_if ();

  euc_iso_case_converter dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .feed    (feed_if),
    .result  (result_if)
  );

  // bytes waiting for the driver, conversions waiting for the output
  raw_byte_t    pending_bytes[$];
  conv_result_t expected_conversions[$];

  // predictor state
  cfg_t             cfg_mirror;
  logic [REM_W-1:0] trail_left;
  logic [CNT_W-1:0] seen_chars;

  int   mismatch_count = 0;
  int   feed_gap;
  int   sink_gap;
  int   hold_left;
  int   idle_cycles;
  logic idle_on;
  logic hold_req;
  logic hold_ack;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    mismatch_count++;
  endtask

  function automatic int pick_gap();
    int roll;
    if (!idle_on) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // case maps
  function automatic logic [BYTE_W-1:0] ascii_case(input logic [BYTE_W-1:0] b,
                                                   input logic up);
    if (up && b >= 8'h61 && b <= 8'h7A) return b - 8'h20;
    if (!up && b >= 8'h41 && b <= 8'h5A) return b + 8'h20;
    return b;
  endfunction

  function automatic logic [BYTE_W-1:0] latin1_case(input logic [BYTE_W-1:0] b,
                                                    input logic up);
    if (up && b >= 8'hE0 && b <= 8'hFE && b != 8'hF7) return b - 8'h20;
    if (!up && b >= 8'hC0 && b <= 8'hDE && b != 8'hD7) return b + 8'h20;
    return b;
  endfunction

  // one input byte in, one expected conversion out; updates framing and count
  function automatic conv_result_t convert_byte(input raw_byte_t item);
    conv_result_t      r;
    logic [BYTE_W-1:0] b;
    logic              counts;
    b = item.in_byte;
    r.out_byte = b;
    counts = 1'b0;
    if (trail_left != 0) begin
      // trailing byte passes through; only euc framing counts on the final one
      trail_left = trail_left - 1'b1;
      counts = cfg_mirror.code_set && (trail_left == 0);
    end else if (cfg_mirror.code_set) begin
      if (!b[7]) begin
        r.out_byte = ascii_case(b, cfg_mirror.to_upper);
        counts = 1'b1;
      end else if (b == SS3_LEAD) begin
        trail_left = 2'd2;
      end else begin
        trail_left = 2'd1;
      end
    end else begin
      if (!cfg_mirror.single_byte_compare && b >= KOR_LO && b <= KOR_HI) begin
        trail_left = 2'd2;
      end else begin
        r.out_byte = ascii_case(b, cfg_mirror.to_upper);
        if (r.out_byte == b) r.out_byte = latin1_case(b, cfg_mirror.to_upper);
      end
      counts = 1'b1;
    end
    if (counts && seen_chars != CNT_MAX) seen_chars = seen_chars + 1'b1;
    r.char_total = seen_chars;
    r.end_of_string = item.last_byte;
    if (item.last_byte) begin
      trail_left = '0;
      seen_chars = '0;
    end
    return r;
  endfunction

  // input driver
  always @(posedge clk) begin : feed_driver
    raw_byte_t item;
    if (rst) begin
      feed_if.valid <= 1'b0;
      feed_gap <= 0;
    end else if (!feed_if.valid || feed_if.ready) begin
      if (feed_gap != 0) begin
        feed_if.valid <= 1'b0;
        feed_gap <= feed_gap - 1;
      end else if (pending_bytes.size() != 0) begin
        item = pending_bytes.pop_front();
        feed_if.valid <= 1'b1;
        feed_if.in_byte <= item.in_byte;
        feed_if.last_byte <= item.last_byte;
        feed_gap <= pick_gap();
      end else begin
        feed_if.valid <= 1'b0;
      end
    end
  end

  // output ready with random gaps and an occasional long hold-off
  always @(posedge clk) begin : result_sink
    if (rst) begin
      result_if.ready <= 1'b0;
      sink_gap <= 0;
      hold_left <= 0;
      hold_ack <= 1'b0;
    end else if (hold_ack != hold_req) begin
      hold_ack <= hold_req;
      hold_left <= LONG_HOLD;
      result_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      result_if.ready <= 1'b0;
    end else if (sink_gap != 0) begin
      sink_gap <= sink_gap - 1;
      result_if.ready <= 1'b0;
    end else begin
      result_if.ready <= 1'b1;
      if (result_if.valid && result_if.ready) sink_gap <= pick_gap();
    end
  end

  // predict on each input transaction, check each output transaction
  always @(posedge clk) begin : scoreboard
    conv_result_t want;
    if (rst) begin
      trail_left = '0;
      seen_chars = '0;
    end else begin
      if (feed_if.valid && feed_if.ready)
        expected_conversions.push_back(convert_byte({feed_if.in_byte, feed_if.last_byte}));
      if (result_if.valid && result_if.ready) begin
        if (expected_conversions.size() == 0) begin
          report_mismatch($sformatf("result byte %02h with nothing expected",
                                    result_if.out_byte));
        end else begin
          want = expected_conversions.pop_front();
          if (result_if.out_byte !== want.out_byte)
            report_mismatch($sformatf("out_byte %02h, expected %02h",
                                      result_if.out_byte, want.out_byte));
          if (result_if.char_total !== want.char_total)
            report_mismatch($sformatf("char_total %0d, expected %0d",
                                      result_if.char_total, want.char_total));
          if (result_if.end_of_string !== want.end_of_string)
            report_mismatch($sformatf("end_of_string %b, expected %b",
                                      result_if.end_of_string, want.end_of_string));
        end
      end
    end
  end

  // watchdog on cycles with no transaction anywhere
  always @(posedge clk) begin : watchdog
    if (rst || (feed_if.valid && feed_if.ready) || (result_if.valid && result_if.ready)
        || (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // apb write: setup then access; junk in the upper data bits
  task automatic write_reg(input reg_idx_t idx, input logic bit_val);
    logic [PDATA_W-1:0] data;
    data = $urandom();
    data[0] = bit_val;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_CODE_SET:  cfg_mirror.code_set = bit_val;
      REG_TO_UPPER:  cfg_mirror.to_upper = bit_val;
      REG_SINGLE_BC: cfg_mirror.single_byte_compare = bit_val;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic code_set, input logic up, input logic sbc);
    write_reg(REG_CODE_SET, code_set);
    write_reg(REG_TO_UPPER, up);
    write_reg(REG_SINGLE_BC, sbc);
    // unmapped address must be ignored
    write_reg(REG_NONE, 1'($urandom_range(0, 1)));
    @(negedge clk);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_bytes.size() != 0 || feed_if.valid || expected_conversions.size() != 0);
    repeat (3) @(negedge clk);
  endtask

  task automatic push_item(input logic [BYTE_W-1:0] b);
    pending_bytes.push_back({b, 1'b0});
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_item(s[i]);
  endtask

  task automatic end_string();
    pending_bytes[$].last_byte = 1'b1;
  endtask

  // one character, well formed for the current mode most of the time
  task automatic push_char();
    int kind;
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      push_item(BYTE_W'($urandom_range(0, 255)));
    end else if (kind < 45) begin
      push_item(BYTE_W'(8'h41 + $urandom_range(0, 25)
                        + ($urandom_range(0, 1) ? 8'h20 : 8'h00)));
    end else if (kind < 55) begin
      push_item(BYTE_W'($urandom_range(0, 127)));
    end else if (cfg_mirror.code_set) begin
      if (kind < 80) begin
        push_item(BYTE_W'($urandom_range(8'hB0, 8'hC8)));
        push_item(BYTE_W'($urandom_range(KOR_LO, KOR_HI)));
      end else if (kind < 90) begin
        push_item(SS3_LEAD);
        push_item(BYTE_W'($urandom_range(KOR_LO, KOR_HI)));
        push_item(BYTE_W'($urandom_range(KOR_LO, KOR_HI)));
      end else begin
        push_item(BYTE_W'($urandom_range(128, 255)));
        push_item(BYTE_W'($urandom_range(0, 255)));
      end
    end else if (!cfg_mirror.single_byte_compare && kind < 80) begin
      push_item(BYTE_W'($urandom_range(KOR_LO, KOR_HI)));
      push_item(BYTE_W'($urandom_range(0, 255)));
      push_item(BYTE_W'(8'h41 + $urandom_range(0, 57)));
    end else begin
      push_item(BYTE_W'($urandom_range(8'hC0, 8'hFF)));
    end
  endtask

  // strings of random characters; the phase may end inside an open string
  task automatic fill_random_phase(input int n_bytes);
    int chars;
    while (pending_bytes.size() < n_bytes) begin
      chars = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 8);
      repeat (chars) push_char();
      if (pending_bytes.size() < n_bytes || $urandom_range(0, 9) < 7) end_string();
    end
  endtask

  initial begin : stimulus
    int combo;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    feed_if.valid = 1'b0;
    feed_if.in_byte = '0;
    feed_if.last_byte = 1'b0;
    result_if.ready = 1'b0;
    cfg_mirror = '0;
    idle_on = 1'b1;
    hold_req = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // iso lower: letter edges, latin-1 edges, a korean group, a group cut short
    set_config(1'b0, 1'b0, 1'b0);
    push_text("AZ@[");
    push_item(8'hC0); push_item(8'hDE); push_item(8'hD7); push_item(8'hFF); push_item(8'h00);
    push_item(KOR_LO); push_text("QR");
    push_item(KOR_HI); push_text("Q");
    end_string();
    wait_idle();

    // iso upper with single-byte compare: korean lead bytes get no skipping
    set_config(1'b0, 1'b1, 1'b1);
    push_text("az`{");
    push_item(8'hE0); push_item(8'hFE); push_item(8'hF7); push_item(KOR_LO);
    end_string();
    wait_idle();

    // euc lower: ascii, ss3 group, two-byte char, truncated char at end
    set_config(1'b1, 1'b0, 1'b0);
    push_text("Az");
    push_item(SS3_LEAD); push_text("BC");
    push_item(8'hB0); push_item(8'hC8);
    push_item(8'hC1);
    end_string();
    wait_idle();

    // mode change mid-character, euc to iso and iso to euc
    push_item(SS3_LEAD);
    wait_idle();
    set_config(1'b0, 1'b1, 1'b0);
    push_text("abc");
    end_string();
    wait_idle();
    push_item(KOR_LO);
    wait_idle();
    set_config(1'b1, 1'b0, 1'b0);
    push_text("XYZ");
    end_string();
    wait_idle();

    // random phases, every register setting first, then random ones
    for (int p = 0; p < RAND_PHASES; p++) begin
      combo = (p < 8) ? p : $urandom_range(0, 7);
      set_config(combo[0], combo[1], combo[2]);
      idle_on = ($urandom_range(0, 3) != 0);
      if (p == 3) hold_req = ~hold_req;
      fill_random_phase(PHASE_BYTES);
      wait_idle();
    end

    repeat (10) @(posedge clk);
    if (expected_conversions.size() != 0)
      report_mismatch($sformatf("%0d conversions never came out", expected_conversions.size()));
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+design
design/eic_pkg.sv
design/eic_in_if.sv
design/eic_out_if.sv
design/eic_core.sv
design/euc_iso_case_converter.sv
verif/euc_iso_case_converter_tb.sv
